@@ sv/snfcp_pkg.sv @@
package snfcp_pkg;

  // Fixed geometry of the device family
  localparam int PAGE_BYTES        = 256;
  localparam int PAGE_BITS         = 8;
  localparam int SECTOR_BYTES      = 4096;
  localparam int SECTOR_BITS       = 12;
  localparam int BLOCK_BYTES       = 65536;
  localparam int BLOCK_BITS        = 16;

  // Defaults for the top-level parameters
  localparam int MAX_REQUEST_BYTES = 4096;
  localparam int READ_CHUNK_BYTES  = 4096;

  // Queue between front and back
  localparam int QUEUE_DEPTH       = 2;
  localparam int QUEUE_AW          = 1;

  localparam logic [7:0] MAKER_ID_EXPECTED = 8'hEF;
  localparam logic [7:0] CAP_MIN           = 8'h10;
  localparam logic [7:0] CAP_LIMIT         = 8'd32;
  localparam logic [4:0] THREE_BYTE_LOG2   = 5'd24;

  // Configuration register indexes
  localparam logic [1:0] REG_PROGRAM_TO = 2'd0;
  localparam logic [1:0] REG_SECTOR_TO  = 2'd1;
  localparam logic [1:0] REG_BLOCK_TO   = 2'd2;
  localparam logic [1:0] REG_CHIP_TO    = 2'd3;

  localparam logic [19:0] PROGRAM_TO_RESET = 20'd3;
  localparam logic [19:0] SECTOR_TO_RESET  = 20'd400;
  localparam logic [19:0] BLOCK_TO_RESET   = 20'd2000;
  localparam logic [19:0] CHIP_TO_RESET    = 20'd200000;

  typedef enum logic [2:0] {
    CMD_PROBE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_PROGRAM = 3'd2,
    CMD_SECTOR  = 3'd3,
    CMD_BLOCK   = 3'd4,
    CMD_CHIP    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STEP_WREN   = 3'd0,
    STEP_ADDR   = 3'd1,
    STEP_BARE   = 3'd2,
    STEP_WAIT   = 3'd3,
    STEP_STATUS = 3'd4
  } step_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_NOT_READY   = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_ID_MISMATCH = 3'd4,
    ST_UNSUPPORTED = 3'd5
  } status_t;

  // SPI opcodes
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_READ3 = 8'h03;
  localparam logic [7:0] OP_READ4 = 8'h13;
  localparam logic [7:0] OP_PP3   = 8'h02;
  localparam logic [7:0] OP_PP4   = 8'h12;
  localparam logic [7:0] OP_SE3   = 8'h20;
  localparam logic [7:0] OP_SE4   = 8'h21;
  localparam logic [7:0] OP_BE3   = 8'hD8;
  localparam logic [7:0] OP_BE4   = 8'hDC;
  localparam logic [7:0] OP_CE    = 8'hC7;

  // Kind of work handed from front to back
  typedef enum logic [2:0] {
    JOB_STATUS = 3'd0,
    JOB_READ   = 3'd1,
    JOB_PROG   = 3'd2,
    JOB_ERASE  = 3'd3,
    JOB_CHIP   = 3'd4
  } job_kind_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] flash_addr;
    logic [12:0] byte_count;
    logic [7:0]  maker_id;
    logic [7:0]  capacity_code;
  } req_t;

  typedef struct packed {
    logic [2:0]  step_kind;
    logic [7:0]  opcode;
    logic [31:0] bus_addr;
    logic [2:0]  addr_bytes;
    logic [12:0] data_bytes;
    logic [19:0] wait_limit_ms;
    logic [2:0]  status;
    logic        last;
  } desc_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [2:0]  status;
    logic [7:0]  opcode;
    logic [31:0] addr;
    logic [12:0] count;
    logic        wide;
    logic [19:0] wait_ms;
  } job_t;

endpackage

@@ sv/spi_nor_flash_command_planner.sv @@
// Channel   Direction  Payload   Handshake
// req       in         req_t     req_valid / req_stall   (one request per word)
// desc      out        desc_t    desc_valid / desc_stall (one descriptor per word)
// cfg       in         20 bits   cfg_we, cfg_index selects a timeout register
//
// A request is classified in the cycle it is taken and queued (two entries).
// The sequencer dequeues a job from idle, then emits one descriptor a cycle while
// desc_stall is low: a status answer is one descriptor, a program three per page.
// The output register decouples the sequencer; desc_stall holds it.
// Synchronous reset clears probe state, queue, sequencer and restores timeouts.
module spi_nor_flash_command_planner
  import snfcp_pkg::*;
#(
  parameter int MAX_REQUEST_BYTES = snfcp_pkg::MAX_REQUEST_BYTES,
  parameter int READ_CHUNK_BYTES  = snfcp_pkg::READ_CHUNK_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_word,
  output logic        desc_valid,
  input  logic        desc_stall,
  output desc_t       desc_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  // front to queue
  logic q_push;
  job_t q_job;
  logic q_full;
  // queue to back
  logic q_pop;
  job_t head_job;
  logic head_valid;

  // Classify requests, hold probe state and timeouts
  snfcp_front #(
    .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_job     (q_job),
    .q_full    (q_full)
  );

  // Buffer classified jobs so each side stalls on its own
  snfcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  // Expand each job into SPI descriptors
  snfcp_back #(
    .READ_CHUNK_BYTES(READ_CHUNK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (head_valid),
    .q_pop      (q_pop),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc_word  (desc_word)
  );

endmodule

@@ sv/snfcp_front.sv @@
module snfcp_front
  import snfcp_pkg::*;
#(
  parameter int MAX_REQUEST_BYTES = snfcp_pkg::MAX_REQUEST_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        q_push,
  output job_t        q_job,
  input  logic        q_full
);

  localparam logic [12:0] MAX_COUNT = 13'(MAX_REQUEST_BYTES);

  logic [19:0] program_to;
  logic [19:0] sector_to;
  logic [19:0] block_to;
  logic [19:0] chip_to;

  logic        probed_ok;
  logic [4:0]  size_log2;
  logic        wide_address;

  logic        accept;
  logic [32:0] dev_size;
  logic [32:0] xfer_end;
  logic [32:0] sector_end;
  logic [32:0] block_end;
  logic        xfer_fits;
  logic        sector_fits;
  logic        block_fits;
  logic        probe_good_cap;
  logic        probe_ok;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign q_push    = accept;

  assign dev_size    = 33'd1 << size_log2;
  assign xfer_end    = {1'b0, req_word.flash_addr} + 33'(req_word.byte_count);
  assign sector_end  = {1'b0, req_word.flash_addr} + 33'(SECTOR_BYTES);
  assign block_end   = {1'b0, req_word.flash_addr} + 33'(BLOCK_BYTES);
  // a non-zero length that ends inside the device also starts inside it
  assign xfer_fits   = xfer_end <= dev_size;
  assign sector_fits = sector_end <= dev_size;
  assign block_fits  = block_end <= dev_size;

  assign probe_good_cap = (req_word.capacity_code >= CAP_MIN) &&
                          (req_word.capacity_code < CAP_LIMIT);
  assign probe_ok = (req_word.maker_id == MAKER_ID_EXPECTED) && probe_good_cap;

  always_comb begin
    q_job        = '0;
    q_job.kind   = JOB_STATUS;
    q_job.status = ST_OK;
    q_job.addr   = req_word.flash_addr;
    q_job.count  = req_word.byte_count;
    q_job.wide   = wide_address;
    priority if (req_word.cmd == CMD_PROBE) begin
      if (req_word.maker_id != MAKER_ID_EXPECTED) begin
        q_job.status = ST_ID_MISMATCH;
      end else if (!probe_good_cap) begin
        q_job.status = ST_UNSUPPORTED;
      end
    end else if (req_word.cmd > CMD_CHIP) begin
      q_job.status = ST_INVALID;
    end else if (!probed_ok) begin
      q_job.status = ST_NOT_READY;
    end else if (req_word.cmd == CMD_READ || req_word.cmd == CMD_PROGRAM) begin
      if (req_word.byte_count > MAX_COUNT) begin
        q_job.status = ST_INVALID;
      end else if (req_word.byte_count == '0) begin
        q_job.status = ST_OK;
      end else if (!xfer_fits) begin
        q_job.status = ST_OUT_OF_RANGE;
      end else if (req_word.cmd == CMD_READ) begin
        q_job.kind   = JOB_READ;
        q_job.opcode = wide_address ? OP_READ4 : OP_READ3;
      end else begin
        q_job.kind    = JOB_PROG;
        q_job.opcode  = wide_address ? OP_PP4 : OP_PP3;
        q_job.wait_ms = program_to;
      end
    end else if (req_word.cmd == CMD_SECTOR) begin
      if (req_word.flash_addr[SECTOR_BITS-1:0] != '0 || !sector_fits) begin
        q_job.status = ST_OUT_OF_RANGE;
      end else begin
        q_job.kind    = JOB_ERASE;
        q_job.opcode  = wide_address ? OP_SE4 : OP_SE3;
        q_job.wait_ms = sector_to;
      end
    end else if (req_word.cmd == CMD_BLOCK) begin
      if (req_word.flash_addr[BLOCK_BITS-1:0] != '0 || !block_fits) begin
        q_job.status = ST_OUT_OF_RANGE;
      end else begin
        q_job.kind    = JOB_ERASE;
        q_job.opcode  = wide_address ? OP_BE4 : OP_BE3;
        q_job.wait_ms = block_to;
      end
    end else begin
      q_job.kind    = JOB_CHIP;
      q_job.opcode  = OP_CE;
      q_job.wait_ms = chip_to;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_to   <= PROGRAM_TO_RESET;
      sector_to    <= SECTOR_TO_RESET;
      block_to     <= BLOCK_TO_RESET;
      chip_to      <= CHIP_TO_RESET;
      probed_ok    <= 1'b0;
      size_log2    <= '0;
      wide_address <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROGRAM_TO: program_to <= cfg_data;
          REG_SECTOR_TO:  sector_to  <= cfg_data;
          REG_BLOCK_TO:   block_to   <= cfg_data;
          REG_CHIP_TO:    chip_to    <= cfg_data;
          default:        program_to <= program_to;
        endcase
      end
      if (accept && req_word.cmd == CMD_PROBE) begin
        probed_ok <= probe_ok;
        if (probe_ok) begin
          size_log2    <= req_word.capacity_code[4:0];
          wide_address <= req_word.capacity_code[4:0] > THREE_BYTE_LOG2;
        end
      end
    end
  end

endmodule

@@ sv/snfcp_queue.sv @@
module snfcp_queue
  import snfcp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic head_valid
);

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW:0]   wr_ptr;
  logic [QUEUE_AW:0]   rd_ptr;

  assign head_valid = wr_ptr != rd_ptr;
  assign full       = (wr_ptr[QUEUE_AW-1:0] == rd_ptr[QUEUE_AW-1:0]) &&
                      (wr_ptr[QUEUE_AW] != rd_ptr[QUEUE_AW]);
  assign head_job   = mem[rd_ptr[QUEUE_AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[QUEUE_AW-1:0]] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

@@ sv/snfcp_back.sv @@
module snfcp_back
  import snfcp_pkg::*;
#(
  parameter int READ_CHUNK_BYTES = snfcp_pkg::READ_CHUNK_BYTES
) (
  input  logic  clk,
  input  logic  rst,
  input  job_t  head_job,
  input  logic  head_valid,
  output logic  q_pop,
  output logic  desc_valid,
  input  logic  desc_stall,
  output desc_t desc_word
);

  localparam logic [12:0] CHUNK = 13'(READ_CHUNK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_STAT, S_READ, S_PWREN, S_PPROG, S_PWAIT, S_EWREN, S_ECMD, S_EWAIT
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [2:0]  job_status;
  logic [7:0]  op;
  logic [31:0] addr;
  logic [31:0] addr_next;
  logic [12:0] rem;
  logic [12:0] rem_next;
  logic        wide;
  logic        bare;
  logic [19:0] wait_ms;
  desc_t       desc_next;

  logic        load;
  logic [12:0] room;
  logic [12:0] read_chunk;
  logic [12:0] prog_chunk;
  logic [12:0] chunk;
  logic [2:0]  ab;

  assign load  = !desc_valid || !desc_stall;
  assign q_pop = (state == S_IDLE) && head_valid;
  assign ab    = wide ? 3'd4 : 3'd3;

  assign room       = 13'(PAGE_BYTES) - 13'(addr[PAGE_BITS-1:0]);
  assign read_chunk = (rem > CHUNK) ? CHUNK : rem;
  assign prog_chunk = (rem > room) ? room : rem;
  assign chunk      = (state == S_READ) ? read_chunk : prog_chunk;

  always_comb begin
    desc_next  = '0;
    state_next = state;
    addr_next  = addr;
    rem_next   = rem;
    unique case (state)
      S_STAT: begin
        desc_next.step_kind = STEP_STATUS;
        desc_next.status    = job_status;
        desc_next.last      = 1'b1;
        state_next          = S_IDLE;
      end
      S_READ: begin
        desc_next.step_kind  = STEP_ADDR;
        desc_next.opcode     = op;
        desc_next.bus_addr   = addr;
        desc_next.addr_bytes = ab;
        desc_next.data_bytes = chunk;
        desc_next.last       = rem <= CHUNK;
        addr_next            = addr + 32'(chunk);
        rem_next             = rem - chunk;
        state_next           = (rem <= CHUNK) ? S_IDLE : S_READ;
      end
      S_PWREN, S_EWREN: begin
        desc_next.step_kind = STEP_WREN;
        desc_next.opcode    = OP_WREN;
        state_next          = (state == S_PWREN) ? S_PPROG : S_ECMD;
      end
      S_PPROG: begin
        desc_next.step_kind  = STEP_ADDR;
        desc_next.opcode     = op;
        desc_next.bus_addr   = addr;
        desc_next.addr_bytes = ab;
        desc_next.data_bytes = chunk;
        addr_next            = addr + 32'(chunk);
        rem_next             = rem - chunk;
        state_next           = S_PWAIT;
      end
      S_PWAIT: begin
        desc_next.step_kind     = STEP_WAIT;
        desc_next.opcode        = OP_RDSR;
        desc_next.wait_limit_ms = wait_ms;
        desc_next.last          = rem == '0;
        state_next              = (rem == '0) ? S_IDLE : S_PWREN;
      end
      S_ECMD: begin
        desc_next.opcode = op;
        if (bare) begin
          desc_next.step_kind = STEP_BARE;
        end else begin
          desc_next.step_kind  = STEP_ADDR;
          desc_next.bus_addr   = addr;
          desc_next.addr_bytes = ab;
        end
        state_next = S_EWAIT;
      end
      S_EWAIT: begin
        desc_next.step_kind     = STEP_WAIT;
        desc_next.opcode        = OP_RDSR;
        desc_next.wait_limit_ms = wait_ms;
        desc_next.last          = 1'b1;
        state_next              = S_IDLE;
      end
      S_IDLE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      desc_valid <= 1'b0;
    end else if (state == S_IDLE) begin
      // drain the output register while the next job is fetched
      if (desc_valid && !desc_stall) desc_valid <= 1'b0;
      if (head_valid) begin
        job_status <= head_job.status;
        op         <= head_job.opcode;
        addr       <= head_job.addr;
        rem        <= head_job.count;
        wide       <= head_job.wide;
        wait_ms    <= head_job.wait_ms;
        bare       <= head_job.kind == JOB_CHIP;
        unique case (head_job.kind)
          JOB_STATUS: state <= S_STAT;
          JOB_READ:   state <= S_READ;
          JOB_PROG:   state <= S_PWREN;
          JOB_ERASE:  state <= S_EWREN;
          JOB_CHIP:   state <= S_EWREN;
          default:    state <= S_STAT;
        endcase
      end
    end else if (load) begin
      desc_word  <= desc_next;
      desc_valid <= 1'b1;
      state      <= state_next;
      addr       <= addr_next;
      rem        <= rem_next;
    end
  end

endmodule
